// File: rtl/fbpa_pkg.sv
// Package for the fixed block pool allocator: sizes, status codes and beat types.
// Used by the channel interfaces, the link store and the top level.
package fbpa_pkg;
    localparam int MaxPages      = 16;
    localparam int BlocksPerPage = 64;
    localparam int SlotW         = $clog2(MaxPages);
    localparam int IdxW          = $clog2(BlocksPerPage);
    localparam int LinkDepth     = MaxPages * BlocksPerPage;
    localparam int LinkAw        = $clog2(LinkDepth);
    localparam int LenW          = $clog2(MaxPages + 1);
    localparam int CntW          = 7;
    localparam int HandleW       = 10;
    localparam int StatusW       = 2;
    localparam int CfgW          = 7;

    localparam logic [StatusW-1:0] ST_OK        = 2'd0;
    localparam logic [StatusW-1:0] ST_NO_SLOT   = 2'd1;
    localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [HandleW-1:0] block_handle;
    } t_req;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [HandleW-1:0] result_handle;
    } t_rsp;

    // One command to the link store: an optional write and a read address.
    typedef struct packed {
        logic              we;
        logic [LinkAw-1:0] waddr;
        logic [IdxW-1:0]   wdata;
        logic [LinkAw-1:0] raddr;
    } t_link_cmd;
endpackage

// File: rtl/fbpa_req_if.sv
// Request channel interface: valid, ready and one request beat.
// Depends on fbpa_pkg.
interface fbpa_req_if;
    import fbpa_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/fbpa_rsp_if.sv
// Response channel interface: valid, ready and one response beat.
// Depends on fbpa_pkg.
interface fbpa_rsp_if;
    import fbpa_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/fbpa_cfg_if.sv
// Configuration write channel: valid, ready and the block count.
// Depends on fbpa_pkg.
interface fbpa_cfg_if;
    import fbpa_pkg::*;
    logic            valid;
    logic            ready;
    logic [CfgW-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/fixed_block_pool_allocator_top.sv
// Fixed block pool allocator: pages of fixed-size blocks with LIFO free lists.
// An allocation walks the listed pages for one with a free block; if none has one, a
// new page is appended and its links are filled first. A free searches the list for
// the page, then compacts the list if the page is released. One beat at a time.
// After reset, and after every configuration write, the link fill of slot 0 runs
// while no request is taken.
module fixed_block_pool_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fbpa_cfg_if.sink    cfg,
    fbpa_req_if.sink    req,
    fbpa_rsp_if.source  rsp
);
    import fbpa_pkg::*;

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_AWALK  = 4'd2;
    localparam logic [3:0] S_ASLOT  = 4'd3;
    localparam logic [3:0] S_FILL   = 4'd4;
    localparam logic [3:0] S_APOP   = 4'd5;
    localparam logic [3:0] S_AWAIT  = 4'd6;
    localparam logic [3:0] S_AFIN   = 4'd7;
    localparam logic [3:0] S_FWALK  = 4'd8;
    localparam logic [3:0] S_FPUSH  = 4'd9;
    localparam logic [3:0] S_FSHIFT = 4'd10;
    localparam logic [3:0] S_RESP   = 4'd11;

    logic [3:0]         r_state;
    logic [CfgW-1:0]    r_eff;
    logic [IdxW-1:0]    r_head  [MaxPages];
    logic [CntW-1:0]    r_count [MaxPages];
    logic [SlotW-1:0]   r_order [MaxPages];
    logic [MaxPages-1:0] r_used;
    logic [LenW-1:0]    r_len;
    logic [LenW-1:0]    r_pos;
    logic [SlotW-1:0]   r_slot;
    logic [IdxW:0]      r_fidx;
    logic [IdxW-1:0]    r_idx;
    logic               r_fill_alloc;
    t_rsp               r_rsp;
    logic               r_rsp_valid;

    t_link_cmd          link_cmd;
    logic [IdxW-1:0]    link_rdata;

    logic [CfgW-1:0]    cfg_eff;
    logic [SlotW-1:0]   pos_slot;
    logic [SlotW-1:0]   free_slot;
    logic               free_slot_ok;
    logic [IdxW-1:0]    fill_next;
    logic [LenW-1:0]    pos_next;

    fbpa_link_ram u_link (
        .i_clk   (i_clk),
        .i_cmd   (link_cmd),
        .o_rdata (link_rdata)
    );

    // Clamp a written block count to 1..BlocksPerPage.
    always_comb begin
        if (cfg.data == '0) begin
            cfg_eff = CfgW'(1);
        end else if ({1'b0, cfg.data} > (CfgW+1)'(BlocksPerPage)) begin
            cfg_eff = CfgW'(BlocksPerPage);
        end else begin
            cfg_eff = cfg.data;
        end
    end

    assign pos_slot = r_order[r_pos[SlotW-1:0]];
    assign pos_next = r_pos + LenW'(1);

    // Lowest unused slot: a small priority search over the used bits.
    always_comb begin
        free_slot    = '0;
        free_slot_ok = 1'b0;
        for (int s = MaxPages - 1; s >= 0; s--) begin
            if (!r_used[s]) begin
                free_slot    = SlotW'(s);
                free_slot_ok = 1'b1;
            end
        end
    end

    // Ascending link for the fill sweep; the last block links to zero.
    always_comb begin
        if ((r_fidx + (IdxW+1)'(1)) < (IdxW+1)'(r_eff)) begin
            fill_next = IdxW'(r_fidx + (IdxW+1)'(1));
        end else begin
            fill_next = '0;
        end
    end

    // Link memory commands.
    always_comb begin
        link_cmd       = '0;
        link_cmd.raddr = {r_slot, r_idx};
        if (r_state == S_INIT || r_state == S_FILL) begin
            link_cmd.we    = 1'b1;
            link_cmd.waddr = {r_slot, r_fidx[IdxW-1:0]};
            link_cmd.wdata = fill_next;
        end else if (r_state == S_FPUSH) begin
            link_cmd.we    = 1'b1;
            link_cmd.waddr = {r_slot, r_idx};
            link_cmd.wdata = r_head[r_slot];
        end
    end

    assign cfg.ready = (r_state == S_IDLE) && !r_rsp_valid;
    assign req.ready = (r_state == S_IDLE) && !r_rsp_valid && !cfg.valid;
    assign rsp.valid = r_rsp_valid;
    assign rsp.data  = r_rsp;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_eff        <= CfgW'(BlocksPerPage);
            r_used       <= MaxPages'(1);
            r_len        <= LenW'(1);
            r_slot       <= '0;
            r_fidx       <= '0;
            r_fill_alloc <= 1'b0;
            r_rsp_valid  <= 1'b0;
            r_pos        <= '0;
            for (int s = 0; s < MaxPages; s++) begin
                r_head[s]  <= '0;
                r_count[s] <= '0;
                r_order[s] <= '0;
            end
        end else begin
            if (rsp.valid && rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_INIT, S_FILL: begin
                    r_fidx <= r_fidx + (IdxW+1)'(1);
                    if (r_fidx == (IdxW+1)'(BlocksPerPage - 1)) begin
                        r_head[r_slot]  <= '0;
                        r_count[r_slot] <= r_eff;
                        r_state         <= r_fill_alloc ? S_APOP : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (cfg.valid && cfg.ready) begin
                        r_eff        <= cfg_eff;
                        r_used       <= MaxPages'(1);
                        r_len        <= LenW'(1);
                        r_slot       <= '0;
                        r_fidx       <= '0;
                        r_fill_alloc <= 1'b0;
                        r_order[0]   <= '0;
                        r_state      <= S_INIT;
                    end else if (req.valid && req.ready) begin
                        r_pos   <= '0;
                        r_slot  <= req.data.block_handle[HandleW-1 -: SlotW];
                        r_idx   <= req.data.block_handle[IdxW-1:0];
                        if (req.data.kind == KIND_ALLOC) begin
                            r_state <= S_AWALK;
                        end else if ((HandleW > SlotW + IdxW &&
                                      (req.data.block_handle >> (SlotW + IdxW)) != '0) ||
                                     {1'b0, req.data.block_handle[IdxW-1:0]} >=
                                     (IdxW+1)'(r_eff)) begin
                            r_rsp.status        <= ST_NOT_FOUND;
                            r_rsp.result_handle <= '0;
                            r_state             <= S_RESP;
                        end else begin
                            r_state <= S_FWALK;
                        end
                    end
                end
                // Walk listed pages for one with a free block.
                S_AWALK: begin
                    if (r_pos >= r_len) begin
                        r_state <= S_ASLOT;
                    end else if (r_count[pos_slot] != '0) begin
                        r_slot  <= pos_slot;
                        r_state <= S_APOP;
                    end else begin
                        r_pos <= pos_next;
                    end
                end
                // Append a new page in the lowest unused slot, or answer no-slot if none is left.
                S_ASLOT: begin
                    if (!free_slot_ok || r_len >= LenW'(MaxPages)) begin
                        r_rsp.status        <= ST_NO_SLOT;
                        r_rsp.result_handle <= '0;
                        r_state             <= S_RESP;
                    end else begin
                        r_used[free_slot]          <= 1'b1;
                        r_order[r_len[SlotW-1:0]]  <= free_slot;
                        r_len                      <= r_len + LenW'(1);
                        r_slot                     <= free_slot;
                        r_fidx                     <= '0;
                        r_fill_alloc               <= 1'b1;
                        r_state                    <= S_FILL;
                    end
                end
                // Pop the head: issue the link read at the head index.
                S_APOP: begin
                    r_idx   <= r_head[r_slot];
                    r_state <= S_AWAIT;
                end
                S_AWAIT: begin
                    r_state <= S_AFIN;
                end
                S_AFIN: begin
                    r_head[r_slot]      <= link_rdata;
                    r_count[r_slot]     <= r_count[r_slot] - CntW'(1);
                    r_rsp.status        <= ST_OK;
                    r_rsp.result_handle <= HandleW'({r_slot, r_idx});
                    r_state             <= S_RESP;
                end
                // Search the list for the handle's slot.
                S_FWALK: begin
                    if (r_pos >= r_len) begin
                        r_rsp.status        <= ST_NOT_FOUND;
                        r_rsp.result_handle <= '0;
                        r_state             <= S_RESP;
                    end else if (pos_slot == r_slot) begin
                        r_state <= S_FPUSH;
                    end else begin
                        r_pos <= pos_next;
                    end
                end
                // Push the block and decide whether the page is released.
                S_FPUSH: begin
                    logic [CntW-1:0] cnt;
                    cnt = (r_count[r_slot] != CntW'(127)) ?
                          r_count[r_slot] + CntW'(1) : r_count[r_slot];
                    r_head[r_slot]      <= r_idx;
                    r_count[r_slot]     <= cnt;
                    r_rsp.status        <= ST_OK;
                    r_rsp.result_handle <= '0;
                    if (r_pos != '0 && cnt >= r_eff) begin
                        r_used[r_slot] <= 1'b0;
                        r_state        <= S_FSHIFT;
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                // Close the gap in the page order one entry a cycle.
                S_FSHIFT: begin
                    if (pos_next < r_len) begin
                        r_order[r_pos[SlotW-1:0]] <= r_order[pos_next[SlotW-1:0]];
                        r_pos                     <= pos_next;
                    end else begin
                        r_len   <= r_len - LenW'(1);
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    r_rsp_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The list never grows past the slot count and is never empty.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len != '0 && r_len <= LenW'(MaxPages))
        else $error("page list length out of range");

    // The first slot stays in use.
    a_slot0_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used[0])
        else $error("first page released");

    // A response beat is only raised out of the response state.
    a_rsp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_valid) |-> $past(r_state) == S_RESP)
        else $error("response raised outside response state");

    // No request is taken while a response is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid |-> !req.ready)
        else $error("request taken with response pending");
endmodule

// File: rtl/fbpa_link_ram.sv
// Per-block free-list link memory, one write and one registered read a cycle.
// Depends on fbpa_pkg.
module fbpa_link_ram (
    input  logic                     i_clk,
    input  fbpa_pkg::t_link_cmd      i_cmd,
    output logic [fbpa_pkg::IdxW-1:0] o_rdata
);
    import fbpa_pkg::*;

    logic [IdxW-1:0] r_mem [LinkDepth];
    logic [IdxW-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        r_rdata <= r_mem[i_cmd.raddr];
    end

    assign o_rdata = r_rdata;
endmodule
